>>> rtl/core/dtdps_pkg.sv
// Shared types and constants for the two-tap delay-line pitch shifter.
`default_nettype none

package dtdps_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int PHASE_W     = 24;
   localparam int LEN_REG_W   = 12;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 24;

   localparam logic [LEN_REG_W-1:0] LEN_RESET = 12'd1323;
   localparam logic [LEN_REG_W-1:0] LEN_MIN   = 12'd2;

   localparam logic [CSR_INDEX_W-1:0] REG_PHASE_STEP   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_DELAY_LENGTH = 2'd1;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_MUL,
      CMD_POS,
      CMD_WRAP,
      CMD_RDA,
      CMD_RDB,
      CMD_INTERP,
      CMD_ENV,
      CMD_ACC,
      CMD_FINAL,
      CMD_CLEAR
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type op;
      logic       tap;
   } dp_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic last;
   } dp_status_type;

endpackage

`default_nettype wire

>>> rtl/core/dtdps_ctrl.sv
// Sequencer that steps the datapath through both taps of each request.
`default_nettype none

module dtdps_ctrl
   import dtdps_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output dp_cmd_type         cmd,
   input  wire dp_status_type status
);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MUL,
      ST_POS,
      ST_WRAP1,
      ST_WRAP2,
      ST_RDA,
      ST_RDB,
      ST_INTERP,
      ST_ENV,
      ST_ACC,
      ST_FINAL
   } state_type;

   state_type state_ff;
   logic      ready_ff;
   logic      valid_ff;
   logic      valid_in;
   logic      tap_ff;
   logic      accept;
   logic      final_go;

   assign accept     = req_tvalid && ready_ff;
   assign final_go   = !valid_ff || rsp_tready;
   assign req_tready = ready_ff;
   assign rsp_tvalid = valid_ff;

   // A new result replaces a taken one in the same cycle.
   assign valid_in = ((state_ff == ST_FINAL) && final_go) ? 1'b1 : (valid_ff && !rsp_tready);

   always_comb begin
      cmd.tap = tap_ff;
      unique case (state_ff)
         ST_CLEAR:  cmd.op = CMD_CLEAR;
         ST_IDLE:   cmd.op = accept ? CMD_LOAD : CMD_NONE;
         ST_MUL:    cmd.op = CMD_MUL;
         ST_POS:    cmd.op = CMD_POS;
         ST_WRAP1:  cmd.op = CMD_WRAP;
         ST_WRAP2:  cmd.op = CMD_WRAP;
         ST_RDA:    cmd.op = CMD_RDA;
         ST_RDB:    cmd.op = CMD_RDB;
         ST_INTERP: cmd.op = CMD_INTERP;
         ST_ENV:    cmd.op = CMD_ENV;
         ST_ACC:    cmd.op = CMD_ACC;
         ST_FINAL:  cmd.op = final_go ? CMD_FINAL : CMD_NONE;
         default:   cmd.op = CMD_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         ready_ff <= 1'b0;
         valid_ff <= 1'b0;
         tap_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         unique case (state_ff)
            ST_CLEAR: begin
               if (status.clear_done) begin
                  state_ff <= ST_IDLE;
                  ready_ff <= 1'b1;
               end
            end
            ST_IDLE: begin
               if (accept) begin
                  state_ff <= ST_MUL;
                  ready_ff <= 1'b0;
                  tap_ff   <= 1'b0;
               end
            end
            ST_MUL:    state_ff <= ST_POS;
            ST_POS:    state_ff <= ST_WRAP1;
            ST_WRAP1:  state_ff <= ST_WRAP2;
            ST_WRAP2:  state_ff <= ST_RDA;
            ST_RDA:    state_ff <= ST_RDB;
            ST_RDB:    state_ff <= ST_INTERP;
            ST_INTERP: state_ff <= ST_ENV;
            ST_ENV:    state_ff <= ST_ACC;
            ST_ACC: begin
               if (tap_ff) begin
                  state_ff <= ST_FINAL;
               end else begin
                  tap_ff   <= 1'b1;
                  state_ff <= ST_MUL;
               end
            end
            ST_FINAL: begin
               if (final_go) begin
                  if (status.last) begin
                     state_ff <= ST_CLEAR;
                  end else begin
                     state_ff <= ST_IDLE;
                     ready_ff <= 1'b1;
                  end
               end
            end
            default: state_ff <= ST_CLEAR;
         endcase
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/dtdps_datapath.sv
// Datapath: registers, delay store, tap arithmetic and the result register.
`default_nettype none

module dtdps_datapath
   import dtdps_pkg::*;
#(
   parameter int BUFFER_DEPTH = 2048
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic [SAMPLE_W-1:0]    req_tdata,
   input  wire logic                   req_tlast,
   output logic [SAMPLE_W-1:0]         rsp_tdata,
   output logic                        rsp_tlast,
   input  wire dp_cmd_type             cmd,
   output dp_status_type               status
);

   localparam int AW  = $clog2(BUFFER_DEPTH);
   localparam int LW  = AW + 1;
   localparam int CW  = (LW > LEN_REG_W) ? LW : LEN_REG_W;
   localparam int PW  = LW + 10;
   localparam int PRW = LW + PHASE_W;

   // Configuration registers.
   logic [PHASE_W-1:0]   step_ff;
   logic [LEN_REG_W-1:0] dlen_ff;

   // Per-block state.
   logic [AW-1:0]      w_ff;
   logic [PHASE_W-1:0] phase_ff;
   logic [AW-1:0]      clr_ff;

   // Per-request working registers.
   logic signed [SAMPLE_W-1:0] sample_ff;
   logic                       last_ff;
   logic [LW-1:0]              len_ff;
   logic [AW-1:0]              weff_ff;
   logic [PRW-1:0]             prod_ff;
   logic [PW-1:0]              pos_ff;
   logic signed [SAMPLE_W-1:0] rd_ff;
   logic signed [SAMPLE_W-1:0] a_ff;
   logic signed [25:0]         interp_ff;
   logic signed [42:0]         wprod_ff;
   logic signed [43:0]         acc_ff;
   logic [SAMPLE_W-1:0]        out_ff;
   logic                       out_last_ff;

   logic signed [SAMPLE_W-1:0] mem [BUFFER_DEPTH];

   logic [CW-1:0]      dlen_c;
   logic [LW-1:0]      len_in;
   logic [PHASE_W-1:0] ph;
   logic [15:0]        env;
   logic [PW-1:0]      span;
   logic [AW-1:0]      idx;
   logic [7:0]         frac;
   logic [LW-1:0]      idx1;
   logic [AW-1:0]      nxt;
   logic [LW-1:0]      w1;
   logic [AW-1:0]      w_next;
   logic [8:0]         wt_a;
   logic signed [25:0] mul_a;
   logic signed [25:0] mul_b;
   logic [43:0]        mag;
   logic [20:0]        shr;
   logic [SAMPLE_W-1:0] q;
   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   logic signed [SAMPLE_W-1:0] mem_wdata;
   logic               mem_re;
   logic [AW-1:0]      mem_raddr;

   always_comb begin
      dlen_c = CW'(dlen_ff);
      if (dlen_c < CW'(LEN_MIN)) begin
         len_in = LW'(LEN_MIN);
      end else if (dlen_c > CW'(BUFFER_DEPTH)) begin
         len_in = LW'(BUFFER_DEPTH);
      end else begin
         len_in = LW'(dlen_c);
      end
   end

   // The second tap sits half a turn away, which is bit 23 inverted.
   assign ph = cmd.tap ? {~phase_ff[PHASE_W-1], phase_ff[PHASE_W-2:0]} : phase_ff;

   always_comb begin
      if (ph[PHASE_W-1]) begin
         env = 16'(((PHASE_W+1)'(1) << PHASE_W) - {1'b0, ph} >> 8);
      end else begin
         env = 16'(ph >> 8);
      end
   end

   assign span = PW'(len_ff) << 8;
   assign idx  = pos_ff[AW+7:8];
   assign frac = pos_ff[7:0];
   assign idx1 = {1'b0, idx} + LW'(1);
   assign nxt  = (idx1 >= len_ff) ? '0 : idx1[AW-1:0];
   assign w1   = {1'b0, weff_ff} + LW'(1);
   assign w_next = (w1 >= len_ff) ? '0 : w1[AW-1:0];
   assign wt_a = 9'd256 - {1'b0, frac};
   assign mul_a = 26'(a_ff) * 26'($signed({1'b0, wt_a}));
   assign mul_b = 26'(rd_ff) * 26'($signed({1'b0, frac}));

   // Truncate toward zero by 23 bits, then saturate.
   always_comb begin
      mag = acc_ff[43] ? 44'(-acc_ff) : 44'(acc_ff);
      shr = mag[43:23];
      if (acc_ff[43]) begin
         q = (shr > 21'd32768) ? 16'h8000 : 16'(-shr);
      end else begin
         q = (shr > 21'd32767) ? 16'h7fff : shr[15:0];
      end
   end

   assign mem_we    = (cmd.op == CMD_FINAL) || (cmd.op == CMD_CLEAR);
   assign mem_waddr = (cmd.op == CMD_CLEAR) ? clr_ff : weff_ff;
   assign mem_wdata = (cmd.op == CMD_CLEAR) ? '0 : sample_ff;
   assign mem_re    = (cmd.op == CMD_RDA) || (cmd.op == CMD_RDB);
   assign mem_raddr = (cmd.op == CMD_RDA) ? idx : nxt;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_ff <= mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         dlen_ff <= LEN_RESET;
      end else if (csr_we) begin
         if (csr_index == REG_PHASE_STEP) begin
            step_ff <= csr_wdata[PHASE_W-1:0];
         end else if (csr_index == REG_DELAY_LENGTH) begin
            dlen_ff <= csr_wdata[LEN_REG_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff     <= '0;
         phase_ff <= '0;
         clr_ff   <= '0;
      end else begin
         if (cmd.op == CMD_CLEAR) begin
            clr_ff <= status.clear_done ? '0 : clr_ff + AW'(1);
         end
         if (cmd.op == CMD_FINAL) begin
            w_ff     <= last_ff ? '0 : w_next;
            phase_ff <= last_ff ? '0 : phase_ff + step_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         CMD_LOAD: begin
            sample_ff <= req_tdata;
            last_ff   <= req_tlast;
            len_ff    <= len_in;
            weff_ff   <= ({1'b0, w_ff} >= len_in) ? '0 : w_ff;
         end
         CMD_MUL:    prod_ff <= PRW'(len_ff) * PRW'(ph);
         CMD_POS: begin
            pos_ff <= (PW'(weff_ff) << 8) + (PW'(len_ff) << 9) - PW'(prod_ff >> 15);
         end
         CMD_WRAP:   pos_ff <= (pos_ff >= span) ? pos_ff - span : pos_ff;
         CMD_RDB:    a_ff <= rd_ff;
         CMD_INTERP: interp_ff <= mul_a + mul_b;
         CMD_ENV:    wprod_ff <= 43'(interp_ff) * 43'($signed({1'b0, env}));
         CMD_ACC:    acc_ff <= cmd.tap ? acc_ff + 44'(wprod_ff) : 44'(wprod_ff);
         CMD_FINAL: begin
            out_ff      <= q;
            out_last_ff <= last_ff;
         end
         CMD_NONE, CMD_RDA, CMD_CLEAR: begin
         end
         default: begin
         end
      endcase
   end

   assign status    = '{clear_done: (clr_ff == AW'(BUFFER_DEPTH - 1)), last: last_ff};
   assign rsp_tdata = out_ff;
   assign rsp_tlast = out_last_ff;

endmodule

`default_nettype wire

>>> rtl/core/dual_tap_delay_pitch_shifter_top.sv
// Top level of the two-tap delay-line pitch shifter.
//
// Requests arrive on req_ (tdata: sample_in, tlast: last_sample) and one
// result per request leaves on rsp_ (tdata: sample_out, tlast: last_out).
// Registers are written through csr_: index 0 is the unsigned Q0.24 phase
// step, index 1 the delay length; write only while the block is idle.
// req_tready returns once the result of the request is formed, so a new
// request is not taken while one is in work: the datapath works the two
// taps one after another, nine steps each, through one multiplier chain
// and the single read port of the delay store, plus one step to write the
// store and the result. The result register lets a new request in while
// a result still waits; if the receiver stalls longer than one request's
// work, the block holds the finished result and waits before the next.
// Reset zeroes every entry of the delay store in a sweep, with
// req_tready low throughout; a request marked last triggers the same sweep
// once its result is formed, and also clears the write position and phase.
`default_nettype none

module dual_tap_delay_pitch_shifter_top
   import dtdps_pkg::*;
#(
   parameter int BUFFER_DEPTH = 2048
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [SAMPLE_W-1:0]    req_tdata,   // [15:0] sample_in
   input  wire logic                   req_tlast,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [SAMPLE_W-1:0]         rsp_tdata,   // [15:0] sample_out
   output logic                        rsp_tlast,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   dp_cmd_type    cmd;
   dp_status_type status;

   dtdps_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   dtdps_datapath #(
      .BUFFER_DEPTH (BUFFER_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

`default_nettype wire

>>> rtl/core/dtdps_checker.sv
// Port-level checks for the pitch shifter and their binding to the top level.
`default_nettype none

module dtdps_checker
   import dtdps_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_tvalid,
   input wire logic                req_tready,
   input wire logic                rsp_tvalid,
   input wire logic                rsp_tready,
   input wire logic [SAMPLE_W-1:0] rsp_tdata,
   input wire logic                rsp_tlast
);

   // A stalled result keeps its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // The store is swept after reset, so no request is taken straight away.
   a_reset_sweep: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("request taken during clearing sweep");

   // One request at a time is in work.
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second request taken while one is in work");

   // A final result starts the clearing sweep.
   a_last_sweep: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) && rsp_tlast |-> !req_tready)
      else $error("request taken after final result before sweep");

endmodule

bind dual_tap_delay_pitch_shifter_top dtdps_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
